// ===== hw/rtl/evr_pkg.sv =====
`timescale 1ns / 1ps
// Package for the Euler XYZ point rotator: widths, constants, payload types
// and the CORDIC arctangent table. No dependencies.
package evr_pkg;

  localparam int unsigned COORD_WIDTH = 32;
  localparam int unsigned ANGLE_WIDTH = 16;

  // two guard bits hold a rotated point before the final clamp
  localparam int unsigned EXT_BITS = 2;
  localparam int unsigned CW_EXT   = COORD_WIDTH + EXT_BITS;

  localparam int unsigned PHASE_W = 32;
  localparam int unsigned FRAC    = 30;
  localparam int unsigned RESID_W = FRAC;
  localparam int unsigned ITERS   = 30;
  localparam int unsigned TRIG_W  = 32;
  localparam int unsigned CX_W    = TRIG_W + 1;
  localparam int unsigned ZW      = 32;
  localparam int unsigned PROD_W  = TRIG_W + CW_EXT;
  localparam int unsigned SUM_W   = PROD_W + 1;

  localparam logic [CX_W-1:0]  CORDIC_GAIN = CX_W'(652032874);
  localparam logic [CX_W-1:0]  CORDIC_ONE  = CX_W'(1) << FRAC;
  localparam logic [SUM_W-1:0] ROUND_HALF  = SUM_W'(1) << (FRAC - 1);

  localparam logic [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;
  localparam int unsigned FIFO_CW    = 3;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_e;

  // classified word held in the front queue
  typedef struct packed {
    logic [COORD_WIDTH-1:0]        px;
    logic [COORD_WIDTH-1:0]        py;
    logic [COORD_WIDTH-1:0]        pz;
    logic [2:0][1:0]               quad;
    logic [2:0][RESID_W-1:0]       resid;
    logic [2:0]                    exact;
  } front_word_t;

  typedef struct packed {
    logic [FIFO_CW-1:0] count;
    logic               vld;
  } fifo_stat_t;

  typedef struct packed {
    logic [TRIG_W-1:0] c;
    logic [TRIG_W-1:0] s;
  } trig_t;

  typedef struct packed {
    logic [CW_EXT-1:0] x;
    logic [CW_EXT-1:0] y;
    logic [CW_EXT-1:0] z;
    trig_t [2:0]       cs;
  } rot_item_t;

  // atan(2^-i) in units of 2^32 per turn
  function automatic logic [ZW-1:0] atan_val(input int unsigned idx);
    logic [ZW-1:0] v;
    case (idx)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A30;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      24: v = 32'h00000029;
      25: v = 32'h00000014;
      26: v = 32'h0000000A;
      27: v = 32'h00000005;
      28: v = 32'h00000003;
      29: v = 32'h00000001;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/evr_in_if.sv =====
`timescale 1ns / 1ps
// Input channel of the point rotator: valid/ready plus point and angles.
// Depends on evr_pkg.
interface evr_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [evr_pkg::COORD_WIDTH-1:0] point_x;
  logic signed [evr_pkg::COORD_WIDTH-1:0] point_y;
  logic signed [evr_pkg::COORD_WIDTH-1:0] point_z;
  logic [evr_pkg::ANGLE_WIDTH-1:0]        angle_about_x;
  logic [evr_pkg::ANGLE_WIDTH-1:0]        angle_about_y;
  logic [evr_pkg::ANGLE_WIDTH-1:0]        angle_about_z;

  modport source (output valid, point_x, point_y, point_z,
                  angle_about_x, angle_about_y, angle_about_z, input ready);
  modport sink (input valid, point_x, point_y, point_z,
                angle_about_x, angle_about_y, angle_about_z, output ready);
endinterface

// ===== hw/rtl/evr_out_if.sv =====
`timescale 1ns / 1ps
// Output channel of the point rotator: valid/ready plus rotated point.
// Depends on evr_pkg.
interface evr_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [evr_pkg::COORD_WIDTH-1:0] rotated_x;
  logic signed [evr_pkg::COORD_WIDTH-1:0] rotated_y;
  logic signed [evr_pkg::COORD_WIDTH-1:0] rotated_z;
  logic                                  saturated;

  modport source (output valid, rotated_x, rotated_y, rotated_z, saturated,
                  input ready);
  modport sink (input valid, rotated_x, rotated_y, rotated_z, saturated,
                output ready);
endinterface

// ===== hw/rtl/evr_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts input words, splits each angle into quadrant and
// residual, and queues the classified word. Depends on evr_pkg, evr_in_if.
module evr_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  evr_in_if.sink               in_i,
  input  logic                 pop_i,
  output evr_pkg::front_word_t word_o,
  output evr_pkg::fifo_stat_t  stat_o
);

  evr_pkg::front_word_t               word_d;
  evr_pkg::front_word_t               mem_q [evr_pkg::FIFO_DEPTH];
  logic [evr_pkg::FIFO_AW-1:0]        wr_ptr_q, rd_ptr_q;
  logic [evr_pkg::FIFO_CW-1:0]        count_q;
  logic [2:0][evr_pkg::ANGLE_WIDTH-1:0] ang;
  logic [2:0][evr_pkg::PHASE_W-1:0]   phase;
  logic                               push, pop;

  assign ang[0] = in_i.angle_about_x;
  assign ang[1] = in_i.angle_about_y;
  assign ang[2] = in_i.angle_about_z;

  // classify each angle into quadrant and residual phase
  always_comb begin
    word_d.px = in_i.point_x;
    word_d.py = in_i.point_y;
    word_d.pz = in_i.point_z;
    for (int j = 0; j < 3; j++) begin
      phase[j] = evr_pkg::PHASE_W'(ang[j]) << (evr_pkg::PHASE_W - evr_pkg::ANGLE_WIDTH);
      word_d.quad[j]  = phase[j][evr_pkg::PHASE_W-1 -: 2];
      word_d.resid[j] = phase[j][evr_pkg::RESID_W-1:0];
      word_d.exact[j] = (phase[j][evr_pkg::RESID_W-1:0] == '0);
    end
  end

  assign in_i.ready = (count_q != evr_pkg::FIFO_CW'(evr_pkg::FIFO_DEPTH));
  assign push = in_i.valid && in_i.ready;
  assign pop  = pop_i && (count_q != '0);

  // hold queued words
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= word_d;
    end
  end

  // advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop) count_q <= count_q + 1'b1;
      else if (pop && !push) count_q <= count_q - 1'b1;
    end
  end

  assign word_o       = mem_q[rd_ptr_q];
  assign stat_o.count = count_q;
  assign stat_o.vld   = (count_q != '0);

endmodule

// ===== hw/rtl/evr_trig.sv =====
`timescale 1ns / 1ps
// Pipelined CORDIC for the three angles, one iteration per stage, with the
// point carried alongside. Depends on evr_pkg.
module evr_trig (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  evr_pkg::front_word_t word_i,
  output logic                 vld_o,
  output evr_pkg::rot_item_t   item_o
);

  localparam int unsigned NS = evr_pkg::ITERS;

  logic                                vld_q   [NS+1];
  logic signed [evr_pkg::CX_W-1:0]     cx_q    [NS+1][3];
  logic signed [evr_pkg::CX_W-1:0]     cy_q    [NS+1][3];
  logic signed [evr_pkg::ZW-1:0]       cz_q    [NS+1][3];
  logic [1:0]                          quad_q  [NS+1][3];
  logic                                exact_q [NS+1][3];
  logic [evr_pkg::COORD_WIDTH-1:0]     pt_q    [NS+1][3];

  // load the first stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pt_q[0][0] <= word_i.px;
      pt_q[0][1] <= word_i.py;
      pt_q[0][2] <= word_i.pz;
      for (int j = 0; j < 3; j++) begin
        cx_q[0][j]    <= evr_pkg::CORDIC_GAIN;
        cy_q[0][j]    <= '0;
        cz_q[0][j]    <= evr_pkg::ZW'(word_i.resid[j]);
        quad_q[0][j]  <= word_i.quad[j];
        exact_q[0][j] <= word_i.exact[j];
      end
    end
  end

  // one micro-rotation per stage
  for (genvar g = 0; g < NS; g++) begin : g_iter
    logic signed [evr_pkg::CX_W-1:0] nx [3];
    logic signed [evr_pkg::CX_W-1:0] ny [3];
    logic signed [evr_pkg::ZW-1:0]   nz [3];

    always_comb begin
      for (int j = 0; j < 3; j++) begin
        if (!cz_q[g][j][evr_pkg::ZW-1]) begin
          nx[j] = cx_q[g][j] - (cy_q[g][j] >>> g);
          ny[j] = cy_q[g][j] + (cx_q[g][j] >>> g);
          nz[j] = cz_q[g][j] - $signed(evr_pkg::atan_val(g));
        end else begin
          nx[j] = cx_q[g][j] + (cy_q[g][j] >>> g);
          ny[j] = cy_q[g][j] - (cx_q[g][j] >>> g);
          nz[j] = cz_q[g][j] + $signed(evr_pkg::atan_val(g));
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[g+1] <= vld_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int j = 0; j < 3; j++) begin
          cx_q[g+1][j]    <= nx[j];
          cy_q[g+1][j]    <= ny[j];
          cz_q[g+1][j]    <= nz[j];
          quad_q[g+1][j]  <= quad_q[g][j];
          exact_q[g+1][j] <= exact_q[g][j];
          pt_q[g+1][j]    <= pt_q[g][j];
        end
      end
    end
  end

  // apply quadrant and the exact-axis case, widen the point
  logic signed [evr_pkg::CX_W-1:0] fx [3];
  logic signed [evr_pkg::CX_W-1:0] fy [3];
  logic signed [evr_pkg::CX_W-1:0] cc [3];
  logic signed [evr_pkg::CX_W-1:0] ss [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      fx[j] = exact_q[NS][j] ? $signed(evr_pkg::CORDIC_ONE) : cx_q[NS][j];
      fy[j] = exact_q[NS][j] ? '0 : cy_q[NS][j];
      case (quad_q[NS][j])
        evr_pkg::QUAD_0: begin cc[j] = fx[j];  ss[j] = fy[j];  end
        evr_pkg::QUAD_1: begin cc[j] = -fy[j]; ss[j] = fx[j];  end
        evr_pkg::QUAD_2: begin cc[j] = -fx[j]; ss[j] = -fy[j]; end
        evr_pkg::QUAD_3: begin cc[j] = fy[j];  ss[j] = -fx[j]; end
        default:         begin cc[j] = fx[j];  ss[j] = fy[j];  end
      endcase
      item_o.cs[j].c = cc[j][evr_pkg::TRIG_W-1:0];
      item_o.cs[j].s = ss[j][evr_pkg::TRIG_W-1:0];
    end
    item_o.x = {{evr_pkg::EXT_BITS{pt_q[NS][0][evr_pkg::COORD_WIDTH-1]}}, pt_q[NS][0]};
    item_o.y = {{evr_pkg::EXT_BITS{pt_q[NS][1][evr_pkg::COORD_WIDTH-1]}}, pt_q[NS][1]};
    item_o.z = {{evr_pkg::EXT_BITS{pt_q[NS][2][evr_pkg::COORD_WIDTH-1]}}, pt_q[NS][2]};
  end

  assign vld_o = vld_q[NS];

endmodule

// ===== hw/rtl/evr_rot.sv =====
`timescale 1ns / 1ps
// One axis rotation in two stages: products, then rounded sums.
// Depends on evr_pkg.
module evr_rot (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  evr_pkg::axis_e     axis_i,
  input  logic               vld_i,
  input  evr_pkg::rot_item_t item_i,
  output logic               vld_o,
  output evr_pkg::rot_item_t item_o
);

  logic signed [evr_pkg::CW_EXT-1:0] a, b;
  logic signed [evr_pkg::TRIG_W-1:0] c, s;
  logic signed [evr_pkg::PROD_W-1:0] ca_q, sb_q, sa_q, cb_q;
  logic signed [evr_pkg::SUM_W-1:0]  sum0, sum1;
  logic [evr_pkg::SUM_W-1:0]         sh0, sh1;
  logic [evr_pkg::CW_EXT-1:0]        t0, t1;
  logic                              vld1_q, vld2_q;
  evr_pkg::rot_item_t                item1_q, item2_q, item_d;

  // pick the plane and its cosine/sine
  always_comb begin
    case (axis_i)
      evr_pkg::AXIS_Y: begin
        a = item_i.z; b = item_i.x;
        c = item_i.cs[1].c; s = item_i.cs[1].s;
      end
      evr_pkg::AXIS_Z: begin
        a = item_i.x; b = item_i.y;
        c = item_i.cs[2].c; s = item_i.cs[2].s;
      end
      default: begin
        a = item_i.y; b = item_i.z;
        c = item_i.cs[0].c; s = item_i.cs[0].s;
      end
    endcase
  end

  // register products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ca_q    <= c * a;
      sb_q    <= s * b;
      sa_q    <= s * a;
      cb_q    <= c * b;
      item1_q <= item_i;
      item2_q <= item_d;
    end
  end

  // sum, round half up, drop the fraction
  always_comb begin
    sum0 = evr_pkg::SUM_W'(ca_q) - evr_pkg::SUM_W'(sb_q) + evr_pkg::ROUND_HALF;
    sum1 = evr_pkg::SUM_W'(sa_q) + evr_pkg::SUM_W'(cb_q) + evr_pkg::ROUND_HALF;
    sh0  = sum0 >>> evr_pkg::FRAC;
    sh1  = sum1 >>> evr_pkg::FRAC;
    t0   = sh0[evr_pkg::CW_EXT-1:0];
    t1   = sh1[evr_pkg::CW_EXT-1:0];
    item_d = item1_q;
    case (axis_i)
      evr_pkg::AXIS_Y: begin item_d.z = t0; item_d.x = t1; end
      evr_pkg::AXIS_Z: begin item_d.x = t0; item_d.y = t1; end
      default:         begin item_d.y = t0; item_d.z = t1; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
    end
  end

  assign vld_o  = vld2_q;
  assign item_o = item2_q;

endmodule

// ===== hw/rtl/euler_xyz_vector_rotator_core.sv =====
`timescale 1ns / 1ps
// Euler XYZ point rotator, top level. Depends on evr_pkg, evr_in_if,
// evr_out_if, evr_front, evr_trig and evr_rot.
//
// Usage:
//   in_i carries a Q16.16 point and three binary angles (a full turn is
//   2^ANGLE_WIDTH). The point is rotated about X, then Y, then Z, and comes
//   out on out_o, clamped to the coordinate range with saturated set when
//   any component was clamped. Both channels are valid/ready; a word moves
//   when both are high.
//   Throughput: one word per cycle while out_o does not stall. From the
//   accepting edge to out_o.valid a word passes the input queue, a load
//   register, 30 CORDIC stages (one iteration each), the product and sum
//   registers of each axis rotation and one output register.
//   A four-word queue sits behind the input, so in_i.ready depends only on
//   its fill level and new words are taken while a result waits on out_o.
//   When out_o stalls, the whole back end holds and the queue fills; then
//   in_i.ready drops.
//   Reset (rst_ni low, asynchronous) empties the queue and clears all valid
//   flags; no result is produced until new words arrive.
module euler_xyz_vector_rotator_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  evr_in_if.sink    in_i,
  evr_out_if.source out_o
);

  evr_pkg::front_word_t front_word;
  evr_pkg::fifo_stat_t  front_stat;
  evr_pkg::rot_item_t   trig_item, rx_item, ry_item, rz_item;
  logic                 trig_vld, rx_vld, ry_vld, rz_vld;
  logic                 en;
  logic                 out_vld_q;
  logic [evr_pkg::COORD_WIDTH-1:0] out_x_q, out_y_q, out_z_q;
  logic [evr_pkg::COORD_WIDTH-1:0] out_x_d, out_y_d, out_z_d;
  logic                 out_sat_q, out_sat_d;

  // advance the back end unless a result is held
  assign en = !out_vld_q || out_o.ready;

  evr_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .pop_i  (en),
    .word_o (front_word),
    .stat_o (front_stat)
  );

  evr_trig u_trig (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (front_stat.vld),
    .word_i (front_word),
    .vld_o  (trig_vld),
    .item_o (trig_item)
  );

  evr_rot u_rot_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .axis_i (evr_pkg::AXIS_X),
    .vld_i  (trig_vld),
    .item_i (trig_item),
    .vld_o  (rx_vld),
    .item_o (rx_item)
  );

  evr_rot u_rot_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .axis_i (evr_pkg::AXIS_Y),
    .vld_i  (rx_vld),
    .item_i (rx_item),
    .vld_o  (ry_vld),
    .item_o (ry_item)
  );

  evr_rot u_rot_z (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .axis_i (evr_pkg::AXIS_Z),
    .vld_i  (ry_vld),
    .item_i (ry_item),
    .vld_o  (rz_vld),
    .item_o (rz_item)
  );

  // clamp each component when its guard bits disagree with the sign
  function automatic logic [evr_pkg::COORD_WIDTH-1:0] clamp(
    input logic [evr_pkg::CW_EXT-1:0] v
  );
    logic [evr_pkg::EXT_BITS:0] top;
    logic [evr_pkg::COORD_WIDTH-1:0] r;
    top = v[evr_pkg::CW_EXT-1:evr_pkg::COORD_WIDTH-1];
    if (top == '0 || top == '1) r = v[evr_pkg::COORD_WIDTH-1:0];
    else if (v[evr_pkg::CW_EXT-1]) r = evr_pkg::COORD_MIN;
    else r = evr_pkg::COORD_MAX;
    return r;
  endfunction

  function automatic logic ovf(input logic [evr_pkg::CW_EXT-1:0] v);
    logic [evr_pkg::EXT_BITS:0] top;
    top = v[evr_pkg::CW_EXT-1:evr_pkg::COORD_WIDTH-1];
    return !(top == '0 || top == '1);
  endfunction

  always_comb begin
    out_x_d   = clamp(rz_item.x);
    out_y_d   = clamp(rz_item.y);
    out_z_d   = clamp(rz_item.z);
    out_sat_d = ovf(rz_item.x) || ovf(rz_item.y) || ovf(rz_item.z);
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= rz_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_x_q   <= out_x_d;
      out_y_q   <= out_y_d;
      out_z_q   <= out_z_d;
      out_sat_q <= out_sat_d;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.rotated_x = out_x_q;
  assign out_o.rotated_y = out_y_q;
  assign out_o.rotated_z = out_z_q;
  assign out_o.saturated = out_sat_q;

  // a saturated word carries at least one clamped component
  a_sat_clamped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.saturated |->
      (out_x_q == evr_pkg::COORD_MAX || out_x_q == evr_pkg::COORD_MIN ||
       out_y_q == evr_pkg::COORD_MAX || out_y_q == evr_pkg::COORD_MIN ||
       out_z_q == evr_pkg::COORD_MAX || out_z_q == evr_pkg::COORD_MIN))
    else $error("saturated set without a clamped component");

  // queue never overfills
  a_fifo_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_stat.count <= evr_pkg::FIFO_CW'(evr_pkg::FIFO_DEPTH))
    else $error("input queue count beyond depth");

  // ready drops only when the queue is full
  a_ready_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> front_stat.count == evr_pkg::FIFO_CW'(evr_pkg::FIFO_DEPTH))
    else $error("input stalled with room in the queue");

  // a stalled back end holds the queue from draining
  a_hold_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready && !(in_i.valid && in_i.ready) |=>
      front_stat.count == $past(front_stat.count))
    else $error("queue drained while output stalled");

endmodule
